// File: design/trr_pkg.sv
`default_nettype none
package trr_pkg;

    localparam int SLOT_TOTAL = 8;
    localparam int SLOT_IDX_W = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int RULE_W     = 49;
    localparam int TIME_W     = 32;
    localparam int S_DATA_W   = 96;
    localparam int M_DATA_W   = 8;

    // enabled, power below 10.0, relay 1, off, cooldown 60
    localparam logic [RULE_W-1:0] SLOT0_RESET = 49'd515664551939;

    typedef enum logic [2:0] {
        TRIG_PWR_ABOVE  = 3'd0,
        TRIG_PWR_BELOW  = 3'd1,
        TRIG_TEMP_ABOVE = 3'd2,
        TRIG_TEMP_BELOW = 3'd3,
        TRIG_MOTION     = 3'd4,
        TRIG_NO_MOTION  = 3'd5,
        TRIG_OCC_ABOVE  = 3'd6,
        TRIG_NEVER      = 3'd7
    } trig_t;

    // Packed rule word, most significant field first
    typedef struct packed {
        logic [15:0]        cooldown;
        logic               action;
        logic [3:0]         relay;
        logic signed [23:0] threshold;
        trig_t              trigger;
        logic               enable;
    } rule_t;

    typedef struct packed {
        logic [TIME_W-1:0]  time_s;
        logic [8:0]         occupancy;
        logic               motion;
        logic signed [23:0] temperature;
        logic signed [23:0] power;
    } reading_t;

    // Fired-time write request from the sequencer to the rule bank
    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] idx;
        logic [TIME_W-1:0]     value;
    } stamp_wr_t;

endpackage
`default_nettype wire

// File: design/threshold_rule_relay_trigger.sv
`default_nettype none
// Threshold rule relay trigger.
// Input stream s_*: one sensor reading per transaction. Output stream m_*: one
// relay command per rule that fires, in rule order; m_tlast marks the last
// command of a reading, and a reading that fires nothing yields no transaction.
// Config channel cfg_*: writes rule word cfg_index (0..7); other indexes are
// ignored. Write only while the block is idle.
// Sequencing: after a reading is accepted the sequencer checks one rule per
// cycle, unless held by an output stall, through the single evaluator (cooldown
// subtract plus threshold compares), rule 0 to RULE_COUNT-1 in ST_CHECK, then
// releases the last held command in ST_DRAIN; s_tready stays low until it is
// back in ST_IDLE, so a new reading is not taken before the last one is done. A
// fired command is held one rule behind so its tlast is known; it moves to the
// output register when the next firing rule is checked, or in ST_DRAIN.
// Stall: when m_tready is low, the output register is full and a command is
// held, the sequencer holds on the next firing rule until the transaction drains.
// Reset (synchronous, aresetn low): rule 0 gets its default word, other rules
// clear, all firing times clear to zero, the output empties.
module threshold_rule_relay_trigger
    import trr_pkg::*;
#(
    parameter int RULE_COUNT = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // power_reading[23:0], temperature_reading[47:24], motion_seen[48],
    // occupancy_level[57:49], time_seconds[89:58], zero pad [95:90]
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // relay_number[3:0], relay_on[4], rule_number[7:5]
    output logic [M_DATA_W-1:0]       m_tdata,
    // final_command
    output logic                      m_tlast,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [RULE_W-1:0]    cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(RULE_COUNT - 1);

    state_t                state_reg,    state_next;
    logic [SLOT_IDX_W-1:0] idx_reg,      idx_next;
    reading_t              reading_reg,  reading_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [M_DATA_W-1:0]   pend_reg,     pend_next;
    logic                  out_vld_reg,  out_vld_next;
    logic [M_DATA_W-1:0]   out_reg,      out_next;
    logic                  last_reg,     last_next;

    rule_t             cur_rule;
    logic [TIME_W-1:0] cur_fired;
    logic              fire;
    logic              out_free;
    stamp_wr_t         stamp_wr;

    assign cfg_ready = 1'b1;

    trr_rule_bank u_bank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid),
        .cfg_idx  (cfg_index),
        .cfg_word (cfg_data),
        .stamp_wr (stamp_wr),
        .rd_idx   (idx_reg),
        .rd_rule  (cur_rule),
        .rd_fired (cur_fired)
    );

    trr_rule_eval u_eval (
        .rule    (cur_rule),
        .fired   (cur_fired),
        .reading (reading_reg),
        .fire    (fire)
    );

    assign out_free = !out_vld_reg || m_tready;

    // Sequence the rule scan and the output hand-off
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        reading_next  = reading_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_next      = out_reg;
        last_next     = last_reg;
        stamp_wr.en    = 1'b0;
        stamp_wr.idx   = idx_reg;
        stamp_wr.value = reading_reg.time_s;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    reading_next  = reading_t'(s_tdata[89:0]);
                    idx_next      = '0;
                    pend_vld_next = 1'b0;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // hold on a firing rule while a command is held and the output register is full
                if (!(fire && pend_vld_reg && !out_free)) begin
                    if (fire) begin
                        stamp_wr.en = 1'b1;
                        if (pend_vld_reg) begin
                            out_vld_next = 1'b1;
                            out_next     = pend_reg;
                            last_next    = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_next     = {idx_reg, cur_rule.action, cur_rule.relay};
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = ST_DRAIN;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                // release the held command as the last one of this reading
                if (!pend_vld_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_next      = pend_reg;
                    last_next     = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        reading_reg <= reading_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
        last_reg    <= last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

// File: design/trr_rule_bank.sv
`default_nettype none
module trr_rule_bank
    import trr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [RULE_W-1:0]     cfg_word,
    input  wire stamp_wr_t             stamp_wr,
    input  wire logic [SLOT_IDX_W-1:0] rd_idx,
    output rule_t                      rd_rule,
    output logic [TIME_W-1:0]          rd_fired
);

    rule_t             rule_reg  [SLOT_TOTAL];
    logic [TIME_W-1:0] fired_reg [SLOT_TOTAL];

    // Take rule writes; drop indexes beyond the slot count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_TOTAL; i++) begin
                rule_reg[i] <= (i == 0) ? rule_t'(SLOT0_RESET) : rule_t'('0);
            end
        end else if (cfg_we && (cfg_idx < CFG_IDX_W'(SLOT_TOTAL))) begin
            rule_reg[cfg_idx[SLOT_IDX_W-1:0]] <= rule_t'(cfg_word);
        end
    end

    // Record the firing time of a rule
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_TOTAL; i++) begin
                fired_reg[i] <= '0;
            end
        end else if (stamp_wr.en) begin
            fired_reg[stamp_wr.idx] <= stamp_wr.value;
        end
    end

    assign rd_rule  = rule_reg[rd_idx];
    assign rd_fired = fired_reg[rd_idx];

endmodule
`default_nettype wire

// File: design/trr_rule_eval.sv
`default_nettype none
module trr_rule_eval
    import trr_pkg::*;
(
    input  wire rule_t             rule,
    input  wire logic [TIME_W-1:0] fired,
    input  wire reading_t          reading,
    output logic                   fire
);

    logic [TIME_W-1:0]  elapsed;
    logic               cooling;
    logic signed [24:0] opnd;
    logic signed [24:0] thr;
    logic               gt;
    logic               lt;
    logic               trig_hit;

    // Cooldown check with wrapping subtraction
    assign elapsed = reading.time_s - fired;
    assign cooling = elapsed < TIME_W'(rule.cooldown);

    // Pick the reading the shared comparator looks at
    always_comb begin
        case (rule.trigger)
            TRIG_PWR_ABOVE, TRIG_PWR_BELOW:
                opnd = {reading.power[23], reading.power};
            TRIG_TEMP_ABOVE, TRIG_TEMP_BELOW:
                opnd = {reading.temperature[23], reading.temperature};
            TRIG_OCC_ABOVE:
                opnd = {16'b0, reading.occupancy};
            default:
                opnd = '0;
        endcase
    end

    assign thr = {rule.threshold[23], rule.threshold};
    assign gt  = opnd > thr;
    assign lt  = opnd < thr;

    always_comb begin
        case (rule.trigger)
            TRIG_PWR_ABOVE, TRIG_TEMP_ABOVE, TRIG_OCC_ABOVE: trig_hit = gt;
            TRIG_PWR_BELOW, TRIG_TEMP_BELOW:                 trig_hit = lt;
            TRIG_MOTION:                                     trig_hit = reading.motion;
            TRIG_NO_MOTION:                                  trig_hit = !reading.motion;
            default:                                         trig_hit = 1'b0;
        endcase
    end

    assign fire = rule.enable && !cooling && trig_hit;

endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import trr_pkg::*;

    localparam int N_RULES        = 8;
    localparam int READING_W      = $bits(reading_t);
    localparam int SETTLE_CYCLES  = N_RULES + 8;
    localparam int DRAIN_LIMIT    = 1000;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 300;

    // Indexes past the rule bank; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_VOID_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_VOID_HI = 4'd15;

    typedef struct packed {
        logic [3:0] relay;
        logic       on;
        logic [2:0] rule;
        logic       last;
    } relay_cmd_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [RULE_W-1:0]     cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_ready;

    // Shadow copy of the rule bank and the firing stamps
    rule_t              rule_bank [N_RULES];
    logic [TIME_W-1:0]  last_fired [N_RULES];

    reading_t    reading_q [$];
    relay_cmd_t  due_cmds [$];
    int          readings_queued   = 0;
    int          readings_accepted = 0;
    int          mismatches        = 0;
    bit          idle_on           = 1'b1;
    logic [31:0] clock_s           = '0;
    int          holdoff_asked     = 0;
    int          holdoff_done      = 0;
    int          holdoff_left      = 0;

    threshold_rule_relay_trigger #(
        .RULE_COUNT(N_RULES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Walk the rules in order and queue one relay command per firing rule
    task automatic forecast_commands(input reading_t rd);
        relay_cmd_t         hits [$];
        relay_cmd_t         cmd;
        logic [TIME_W-1:0]  elapsed;
        logic signed [23:0] thr;
        logic signed [23:0] pw;
        logic signed [23:0] tp;
        logic signed [24:0] occ;
        logic               fire;
        pw  = rd.power;
        tp  = rd.temperature;
        occ = {16'd0, rd.occupancy};
        for (int i = 0; i < N_RULES; i++) begin
            thr     = rule_bank[i].threshold;
            elapsed = rd.time_s - last_fired[i];
            fire    = 1'b0;
            if (rule_bank[i].enable && elapsed >= {16'd0, rule_bank[i].cooldown}) begin
                case (rule_bank[i].trigger)
                    TRIG_PWR_ABOVE:  fire = pw > thr;
                    TRIG_PWR_BELOW:  fire = pw < thr;
                    TRIG_TEMP_ABOVE: fire = tp > thr;
                    TRIG_TEMP_BELOW: fire = tp < thr;
                    TRIG_MOTION:     fire = rd.motion;
                    TRIG_NO_MOTION:  fire = !rd.motion;
                    TRIG_OCC_ABOVE:  fire = occ > thr;
                    default:         fire = 1'b0;
                endcase
            end
            if (fire) begin
                last_fired[i] = rd.time_s;
                cmd.relay = rule_bank[i].relay;
                cmd.on    = rule_bank[i].action;
                cmd.rule  = i[2:0];
                cmd.last  = 1'b0;
                hits.push_back(cmd);
            end
        end
        // Flag the last command of this reading
        foreach (hits[k]) begin
            cmd      = hits[k];
            cmd.last = (k == hits.size() - 1);
            due_cmds.push_back(cmd);
        end
    endtask

    task automatic check_command(input logic [M_DATA_W-1:0] data, input logic last);
        relay_cmd_t want;
        if (due_cmds.size() == 0) begin
            report_mismatch($sformatf("unexpected command relay=%0d on=%0b rule=%0d last=%0b",
                                      data[3:0], data[4], data[7:5], last));
        end else begin
            want = due_cmds.pop_front();
            if (data[3:0] != want.relay)
                report_mismatch($sformatf("rule %0d: relay_number %0d, want %0d",
                                          want.rule, data[3:0], want.relay));
            if (data[4] != want.on)
                report_mismatch($sformatf("rule %0d: relay_on %0b, want %0b",
                                          want.rule, data[4], want.on));
            if (data[7:5] != want.rule)
                report_mismatch($sformatf("rule_number %0d, want %0d", data[7:5], want.rule));
            if (last != want.last)
                report_mismatch($sformatf("rule %0d: final_command %0b, want %0b",
                                          want.rule, last, want.last));
        end
    endtask

    // Input driver: feed readings from the pending queue
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                forecast_commands(reading_t'(s_tdata[READING_W-1:0]));
                readings_accepted++;
                gap_left = pick_gap();
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered transaction
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (reading_q.size() != 0) begin
                s_tdata  <= {{(S_DATA_W - READING_W){1'b0}}, reading_q.pop_front()};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor: check each command, stall at random or during a hold-off
    int stall_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready)
                check_command(m_tdata, m_tlast);
            if (holdoff_left != 0) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (holdoff_asked != holdoff_done) begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= holdoff_done + 1;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    // End the run when nothing moves for too long
    int quiet_cycles = 0;
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: FAIL");
        $finish;
    end

    task automatic write_rule(input logic [CFG_IDX_W-1:0] idx, input rule_t w);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= w;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < SLOT_TOTAL)
            rule_bank[idx[SLOT_IDX_W-1:0]] = w;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_reading(input reading_t rd);
        reading_q.push_back(rd);
        readings_queued++;
    endtask

    // Wait for all readings and commands, then let the sequencer finish its walk
    task automatic drain_and_settle();
        int waited;
        waited = 0;
        while (readings_accepted != readings_queued) @(posedge aclk);
        while (due_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (due_cmds.size() != 0) begin
            report_mismatch($sformatf("%0d commands never arrived", due_cmds.size()));
            due_cmds.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic reading_t mk_reading(input int pw, input int tp, input bit mo,
                                            input int occ, input logic [31:0] t);
        reading_t rd;
        rd.power       = pw[23:0];
        rd.temperature = tp[23:0];
        rd.motion      = mo;
        rd.occupancy   = occ[8:0];
        rd.time_s      = t;
        return rd;
    endfunction

    // Near the interesting thresholds mostly, full range now and then
    function automatic logic [23:0] rand_q16_8();
        logic [31:0] bits32;
        int          v;
        bits32 = $urandom;
        v      = $urandom_range(0, 8000) - 4000;
        if ($urandom_range(0, 4) == 0) return bits32[23:0];
        return v[23:0];
    endfunction

    function automatic reading_t random_reading();
        reading_t    rd;
        logic [31:0] bits32;
        int          v;
        int          pick;
        bits32         = $urandom;
        rd.power       = rand_q16_8();
        rd.temperature = rand_q16_8();
        rd.motion      = bits32[0];
        v              = $urandom_range(0, 300);
        rd.occupancy   = ($urandom_range(0, 4) == 0) ? bits32[13:5] : v[8:0];
        // Advance time in small steps, with rare jumps that wrap
        pick = $urandom_range(0, 19);
        if (pick == 0)
            clock_s = $urandom;
        else if (pick < 3)
            clock_s = clock_s + $urandom_range(0, 70000);
        else
            clock_s = clock_s + $urandom_range(0, 40);
        rd.time_s = clock_s;
        return rd;
    endfunction

    function automatic rule_t random_rule();
        rule_t       r;
        logic [31:0] bits32;
        int          v;
        bits32    = $urandom;
        r.enable  = ($urandom_range(0, 9) != 0);
        r.trigger = trig_t'(bits32[2:0]);
        r.relay   = bits32[6:3];
        r.action  = bits32[7];
        v         = $urandom_range(0, 540) - 20;
        r.threshold = (r.trigger == TRIG_OCC_ABOVE) ? v[23:0] : rand_q16_8();
        v          = $urandom_range(0, 90);
        r.cooldown = (bits32[10:8] == 3'd0) ? bits32[31:16] : v[15:0];
        return r;
    endfunction

    // One rule per trigger, thresholds set at the edges the readings probe
    function automatic rule_t directed_rule(input trig_t t);
        rule_t r;
        r         = '0;
        r.enable  = 1'b1;
        r.trigger = t;
        r.relay   = {1'b1, t};
        r.action  = t[0];
        case (t)
            TRIG_PWR_ABOVE, TRIG_PWR_BELOW: r.threshold = '0;
            TRIG_TEMP_ABOVE: r.threshold = 24'sd2560;
            TRIG_TEMP_BELOW: r.threshold = -24'sd2560;
            TRIG_MOTION: begin
                r.threshold = '1;
                r.cooldown  = 16'hFFFF;
            end
            TRIG_NO_MOTION:  r.threshold = 24'h7FFFFF;
            TRIG_OCC_ABOVE:  r.threshold = 24'sd256;
            default:         r = '1;
        endcase
        return r;
    endfunction

    initial begin
        rule_t w;
        foreach (rule_bank[i]) begin
            rule_bank[i]  = '0;
            last_fired[i] = '0;
        end
        rule_bank[0] = SLOT0_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Default rule: power below 10.0 with a 60 s cooldown
        send_reading(mk_reading(0, 0, 1'b0, 0, 32'd0));
        send_reading(mk_reading(0, 0, 1'b0, 0, 32'd100));
        send_reading(mk_reading(0, 0, 1'b0, 0, 32'd130));
        send_reading(mk_reading(2559, 0, 1'b0, 0, 32'd160));
        send_reading(mk_reading(2560, 0, 1'b0, 0, 32'd300));
        send_reading(mk_reading(-8388608, 8388607, 1'b1, 511, 32'd400));
        send_reading(mk_reading(8388607, -8388608, 1'b0, 256, 32'd500));
        drain_and_settle();

        // Every trigger code once, plus writes past the bank
        for (int s = 0; s < SLOT_TOTAL; s++)
            write_rule(s[CFG_IDX_W-1:0], directed_rule(trig_t'(s[2:0])));
        write_rule(CFG_IDX_VOID_LO, '1);
        write_rule(CFG_IDX_VOID_HI, '1);
        send_reading(mk_reading(0, 2560, 1'b0, 256, 32'h0001_0000));
        send_reading(mk_reading(1, 2561, 1'b1, 257, 32'h0001_0001));
        send_reading(mk_reading(-1, -2561, 1'b1, 511, 32'h0001_0002));
        send_reading(mk_reading(8388607, 8388607, 1'b1, 0, 32'hFFFF_FFFF));
        send_reading(mk_reading(-8388608, -8388608, 1'b1, 0, 32'h0000_0005));
        send_reading(mk_reading(0, 0, 1'b1, 0, 32'h0000_FFFE));
        send_reading(mk_reading(0, 0, 1'b0, 0, 32'h0000_FFFF));
        drain_and_settle();

        // All rules cleared: readings pass with no command
        for (int s = 0; s < SLOT_TOTAL; s++)
            write_rule(s[CFG_IDX_W-1:0], '0);
        clock_s = 32'h0002_0000;
        repeat (3) send_reading(random_reading());
        drain_and_settle();

        // Every rule fires on nearly every reading; hold off the output meanwhile
        for (int s = 0; s < SLOT_TOTAL; s++) begin
            w           = '0;
            w.enable    = 1'b1;
            w.trigger   = (s % 2 == 1) ? TRIG_TEMP_BELOW : TRIG_PWR_ABOVE;
            w.threshold = (s % 2 == 1) ? 24'h7FFFFF : 24'h800000;
            w.relay     = s[3:0];
            w.action    = s[0];
            write_rule(s[CFG_IDX_W-1:0], w);
        end
        holdoff_asked++;
        repeat (20) send_reading(random_reading());
        drain_and_settle();

        // Random rule sets; one phase runs with no idling on either side
        for (int ph = 0; ph < 4; ph++) begin
            idle_on = (ph != 2);
            for (int s = 0; s < SLOT_TOTAL; s++)
                write_rule(s[CFG_IDX_W-1:0], random_rule());
            repeat (35) send_reading(random_reading());
            drain_and_settle();
        end
        idle_on = 1'b1;

        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
